// File: design/seam_feather_blend_assert.svh
// assertion macros shared by the seam blend design
`ifndef SEAM_FEATHER_BLEND_ASSERT_SVH
`define SEAM_FEATHER_BLEND_ASSERT_SVH

// condition implies consequence in the same cycle
`define SFB_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error("seam blend check failed");

// condition implies consequence in the next cycle
`define SFB_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error("seam blend check failed");

`endif

// File: design/sfb_pkg.sv
// types and constants of the seam blend pipeline
`default_nettype none
package sfb_pkg;

	localparam int COL_W  = 12;
	localparam int LW_W   = 13;
	localparam int CH_W   = 8;
	// remainder of the divider holds twice the largest span
	localparam int REM_W  = LW_W + 1;

	localparam logic [LW_W-1:0] LEFT_WIDTH_RST = 13'd4096;
	localparam logic [COL_W-1:0] OVERLAP_START_RST = 12'd0;

	// configuration register indexes
	localparam logic CFG_OVERLAP_START = 1'b0;
	localparam logic CFG_LEFT_WIDTH    = 1'b1;

	// per-pixel handling
	localparam logic [1:0] MODE_LEFT  = 2'd0;
	localparam logic [1:0] MODE_RIGHT = 2'd1;
	localparam logic [1:0] MODE_BLEND = 2'd2;
	localparam logic [1:0] MODE_FULL  = 2'd3;

	// channel 0 blue, 1 green, 2 red
	typedef struct packed {
		logic [2:0][CH_W-1:0] l;
		logic [2:0][CH_W-1:0] r;
	} pix_t;

	typedef struct packed {
		logic [1:0] mode;
		pix_t       pix;
	} item_t;

endpackage
`default_nettype wire

// File: design/sfb_front.sv
// first stage: region decode and dividend of the left weight
`default_nettype none
module sfb_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [sfb_pkg::COL_W-1:0] column,
	input  wire sfb_pkg::pix_t             pix,
	input  wire logic [sfb_pkg::COL_W-1:0] overlap_start,
	input  wire logic [sfb_pkg::LW_W-1:0]  left_width,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output sfb_pkg::item_t                 out_item,
	output logic [sfb_pkg::LW_W-1:0]       out_num
);

	logic                     v_s1;
	sfb_pkg::item_t           item_s1;
	logic [sfb_pkg::LW_W-1:0] num_s1;
	logic [1:0]               mode;
	logic [sfb_pkg::LW_W-1:0] col_x;

	assign col_x    = {1'b0, column};
	assign in_ready = !v_s1 || out_ready;

	// region decode, right of the left image wins
	always_comb begin
		priority if (col_x >= left_width) begin
			mode = sfb_pkg::MODE_RIGHT;
		end else if (column < overlap_start) begin
			mode = sfb_pkg::MODE_LEFT;
		end else if (pix.r == '0) begin
			mode = sfb_pkg::MODE_FULL;
		end else begin
			mode = sfb_pkg::MODE_BLEND;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.mode <= mode;
			item_s1.pix  <= pix;
			num_s1       <= left_width - col_x;
		end
	end

	assign out_valid = v_s1;
	assign out_item  = item_s1;
	assign out_num   = num_s1;

endmodule
`default_nettype wire

// File: design/sfb_div.sv
// restoring divider, one quotient bit per pipeline stage
`default_nettype none
module sfb_div #(
	parameter int QW = 17
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire sfb_pkg::item_t           in_item,
	input  wire logic [sfb_pkg::LW_W-1:0] in_num,
	input  wire logic [sfb_pkg::LW_W-1:0] span,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output sfb_pkg::item_t                out_item,
	output logic [QW-1:0]                 out_quo
);

	localparam int RW = sfb_pkg::REM_W;

	logic                 v_sk   [QW];
	logic                 rdy_sk [QW];
	logic [RW-1:0]        rem_sk [QW];
	logic [QW-1:0]        quo_sk [QW];
	sfb_pkg::item_t       item_sk[QW];
	logic [RW-1:0]        span_x;

	assign span_x   = {1'b0, span};
	assign in_ready = rdy_sk[0];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic           v_in;
			logic [RW-1:0]  trial;
			logic [QW-1:0]  quo_in;
			sfb_pkg::item_t item_in;
			logic           ge;

			// stage inputs, first stage takes the dividend as is
			if (k == 0) begin : g_first
				assign v_in    = in_valid;
				assign trial   = {1'b0, in_num};
				assign quo_in  = '0;
				assign item_in = in_item;
			end else begin : g_next
				assign v_in    = v_sk[k-1];
				assign trial   = {rem_sk[k-1][RW-2:0], 1'b0};
				assign quo_in  = quo_sk[k-1];
				assign item_in = item_sk[k-1];
			end

			if (k == QW - 1) begin : g_last
				assign rdy_sk[k] = !v_sk[k] || out_ready;
			end else begin : g_mid
				assign rdy_sk[k] = !v_sk[k] || rdy_sk[k+1];
			end

			assign ge = trial >= span_x;

			// valid bit
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sk[k] <= 1'b0;
				end else if (rdy_sk[k]) begin
					v_sk[k] <= v_in;
				end
			end

			// trial subtract and quotient bit
			always_ff @(posedge clk) begin
				if (rdy_sk[k] && v_in) begin
					rem_sk[k]  <= ge ? (trial - span_x) : trial;
					quo_sk[k]  <= {quo_in[QW-2:0], ge};
					item_sk[k] <= item_in;
				end
			end
		end
	endgenerate

	assign out_valid = v_sk[QW-1];
	assign out_item  = item_sk[QW-1];
	assign out_quo   = quo_sk[QW-1];

endmodule
`default_nettype wire

// File: design/sfb_mix.sv
// weight select, channel products and final sum with region select
`default_nettype none
module sfb_mix #(
	parameter int FRAC = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire sfb_pkg::item_t                 in_item,
	input  wire logic [FRAC:0]                  in_quo,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [2:0][sfb_pkg::CH_W-1:0]       out_pix
);

	localparam int QW = FRAC + 1;
	localparam int PW = sfb_pkg::CH_W + QW;
	localparam logic [QW-1:0] ONE_W = QW'(1) << FRAC;

	logic                           v_s1, v_s2, v_s3;
	logic                           rdy_s1, rdy_s2, rdy_s3;
	sfb_pkg::item_t                 item_s1, item_s2;
	logic [QW-1:0]                  w_s1;
	logic [QW-1:0]                  w_inv;
	logic [2:0][PW-1:0]             pl_s2, pr_s2;
	logic [2:0][sfb_pkg::CH_W-1:0]  pix_s3;
	logic [2:0][sfb_pkg::CH_W-1:0]  mixed;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign w_inv    = ONE_W - w_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// weight, a black right pixel takes the full left weight
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= in_item;
			w_s1    <= (in_item.mode == sfb_pkg::MODE_FULL) ? ONE_W : in_quo;
		end
	end

	// channel products
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			item_s2 <= item_s1;
			for (int c = 0; c < 3; c++) begin
				pl_s2[c] <= PW'(item_s1.pix.l[c]) * PW'(w_s1);
				pr_s2[c] <= PW'(item_s1.pix.r[c]) * PW'(w_inv);
			end
		end
	end

	// sum and drop the fraction
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mixed[c] = sfb_pkg::CH_W'((pl_s2[c] + pr_s2[c]) >> FRAC);
		end
	end

	// output word, region select
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			unique case (item_s2.mode)
				sfb_pkg::MODE_LEFT:  pix_s3 <= item_s2.pix.l;
				sfb_pkg::MODE_RIGHT: pix_s3 <= item_s2.pix.r;
				sfb_pkg::MODE_BLEND: pix_s3 <= mixed;
				sfb_pkg::MODE_FULL:  pix_s3 <= mixed;
			endcase
		end
	end

	assign out_valid = v_s3;
	assign out_pix   = pix_s3;

endmodule
`default_nettype wire

// File: design/seam_feather_blend.sv
// path: an accepted pair passes the front stage, the divider stages and the mix stages to the result word
// throughput: one pixel pair per cycle while m_tready holds; the divider gives one weight bit per stage
// each stage holds its word under back-pressure, so the pipe fills its bubbles
// reset: arst_n clears all valid bits and sets overlap_start to 0, left_width to 4096
// no clearing pass; the block accepts words as soon as reset is released
`default_nettype none
`include "seam_feather_blend_assert.svh"
module seam_feather_blend #(
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel pair in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// column[11:0], left_b, left_g, left_r, right_b, right_g, right_r, zero pad[63:60]
	input  wire logic [63:0] s_tdata,
	// blended pixel out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_b[7:0], out_g[15:8], out_r[23:16]
	output logic [23:0]      m_tdata,
	// register writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);

	localparam int QW = WEIGHT_FRAC_BITS + 1;

	logic [sfb_pkg::COL_W-1:0] overlap_start_q;
	logic [sfb_pkg::LW_W-1:0]  left_width_q;
	logic [sfb_pkg::LW_W-1:0]  span_q;

	logic [sfb_pkg::COL_W-1:0] column;
	logic [7:0]                left_b, left_g, left_r, right_b, right_g, right_r;
	logic [7:0]                out_b, out_g, out_r;
	sfb_pkg::pix_t             in_pix;

	logic                      fr_valid, fr_ready;
	sfb_pkg::item_t            fr_item;
	logic [sfb_pkg::LW_W-1:0]  fr_num;
	logic                      dv_valid, dv_ready;
	sfb_pkg::item_t            dv_item;
	logic [QW-1:0]             dv_quo;
	logic [2:0][7:0]           mx_pix;

	// field unpacking
	assign column  = s_tdata[11:0];
	assign left_b  = s_tdata[19:12];
	assign left_g  = s_tdata[27:20];
	assign left_r  = s_tdata[35:28];
	assign right_b = s_tdata[43:36];
	assign right_g = s_tdata[51:44];
	assign right_r = s_tdata[59:52];
	assign in_pix.l = {left_r, left_g, left_b};
	assign in_pix.r = {right_r, right_g, right_b};

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overlap_start_q <= sfb_pkg::OVERLAP_START_RST;
			left_width_q    <= sfb_pkg::LEFT_WIDTH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfb_pkg::CFG_OVERLAP_START: overlap_start_q <= cfg_data[11:0];
				sfb_pkg::CFG_LEFT_WIDTH:    left_width_q    <= cfg_data;
			endcase
		end
	end

	// overlap span, settled before any word reaches the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= sfb_pkg::LEFT_WIDTH_RST;
		end else begin
			span_q <= left_width_q - {1'b0, overlap_start_q};
		end
	end

	sfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.column        (column),
		.pix           (in_pix),
		.overlap_start (overlap_start_q),
		.left_width    (left_width_q),
		.out_valid     (fr_valid),
		.out_ready     (fr_ready),
		.out_item      (fr_item),
		.out_num       (fr_num)
	);

	sfb_div #(
		.QW (QW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.in_num    (fr_num),
		.span      (span_q),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_item  (dv_item),
		.out_quo   (dv_quo)
	);

	sfb_mix #(
		.FRAC (WEIGHT_FRAC_BITS)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.in_item   (dv_item),
		.in_quo    (dv_quo),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (mx_pix)
	);

	// result packing
	assign out_b   = mx_pix[0];
	assign out_g   = mx_pix[1];
	assign out_r   = mx_pix[2];
	assign m_tdata = {out_r, out_g, out_b};

	// an open output lets every stage move
	`SFB_ASSERT_NOW(a_ready_chain, clk, arst_n, m_tready, s_tready)
	// a blending word has a dividend within the span
	`SFB_ASSERT_NOW(a_num_range, clk, arst_n, fr_valid && fr_item.mode == sfb_pkg::MODE_BLEND,
		fr_num != '0 && fr_num <= span_q)
	// the divider never gives a weight above one
	`SFB_ASSERT_NOW(a_quo_range, clk, arst_n, dv_valid && dv_item.mode == sfb_pkg::MODE_BLEND,
		dv_quo <= (QW'(1) << WEIGHT_FRAC_BITS))

endmodule
`default_nettype wire
